@@ rtl/core/wcg_pkg.sv @@
// Shared types, constants and the sRGB linearization table builder for the
// WCAG contrast grader. Used by every module of the block; depends on nothing.
package wcg_pkg;

  localparam int LumFracBitsDef   = 16;
  localparam int RatioFracBitsDef = 8;

  localparam int ChanW   = 8;
  localparam int RatioW  = 13;
  localparam int GradeW  = 2;

  // Integer bits of the quotient: the ratio never reaches 32.
  localparam int RatioIntBits = 5;
  localparam int RatioSatInt  = 21;

  // Luminance weights out of 65536.
  localparam int WeightW = 16;
  localparam logic [WeightW-1:0] WeightRed   = 16'd13933;
  localparam logic [WeightW-1:0] WeightGreen = 16'd46871;
  localparam logic [WeightW-1:0] WeightBlue  = 16'd4732;

  localparam int LinWMax     = 25;
  localparam int LinTabDepth = 256;

  localparam int FifoDepth = 8;

  // Configuration register indexes.
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgBgRed   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBgGreen = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBgBlue  = 2'd2;

  localparam logic [ChanW-1:0] BgRedRst   = 8'd17;
  localparam logic [ChanW-1:0] BgGreenRst = 8'd20;
  localparam logic [ChanW-1:0] BgBlueRst  = 8'd24;

  typedef enum logic [GradeW-1:0] {
    GradeFail    = 2'd0,
    GradeAaLarge = 2'd1,
    GradeAa      = 2'd2,
    GradeAaa     = 2'd3
  } grade_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } color_t;

  typedef struct packed {
    logic [RatioW-1:0] ratio;
    logic [GradeW-1:0] grade_code;
  } result_t;

  typedef logic [LinWMax-1:0] lin_tab_t [LinTabDepth];

  // Builds the sRGB-to-linear table at elaboration. The power segment is
  // ((c/255 + 0.055)/1.055)^2.4, formed as t^2 times the fifth root of t^2 in
  // Q30, the root found by bisection. Entries are rounded half up.
  function automatic lin_tab_t build_lin_table(int unsigned frac_bits);
    lin_tab_t tab;
    longint unsigned cc;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned p;
    longint unsigned v;
    longint unsigned sh;
    int c;
    int k;
    for (c = 0; c < LinTabDepth; c++) begin
      cc = longint'(c);
      if (c <= 10) begin
        v = (cc * 64'd100 * (64'd1 << frac_bits) + 64'd164730) / 64'd329460;
        tab[c] = LinWMax'(v);
      end else begin
        t  = ((64'd1000 * cc + 64'd14025) << 30) / 64'd269025;
        t2 = (t * t) >> 30;
        lo = 64'd0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
          mid = lo + ((hi - lo + 64'd1) >> 1);
          p = mid;
          for (k = 0; k < 4; k++) begin
            p = (p * mid) >> 30;
          end
          if (p <= t2) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
        v  = (t2 * lo) >> 30;
        sh = 64'd30 - longint'(frac_bits);
        tab[c] = LinWMax'((v + (64'd1 << (sh - 64'd1))) >> sh);
      end
    end
    return tab;
  endfunction

endpackage

@@ rtl/core/wcg_front.sv @@
// Front end of the contrast grader: table lookups, weighted luminance sums
// and the bright/dark ordering. Depends on wcg_pkg.
module wcg_front
  import wcg_pkg::*;
#(
  parameter int LumFracBits = LumFracBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  color_t               fg_i,
  input  color_t               bg_i,
  output logic                 push_o,
  output logic [LumFracBits+1:0] bright_o,
  output logic [LumFracBits+1:0] dark_o,
  output logic [1:0]           inflight_o
);

  localparam int LumW  = LumFracBits + 1;
  localparam int DenW  = LumW + 1;
  localparam int ProdW = LumW + WeightW;
  localparam int SumW  = ProdW + 2;
  localparam logic [DenW-1:0] Offset =
    DenW'(((64'd1 << LumFracBits) * 64'd5 + 64'd50) / 64'd100);
  localparam lin_tab_t LinTab = build_lin_table(LumFracBits);

  // Index 0..2 foreground red/green/blue, 3..5 background.
  logic [LumW-1:0]  lin_w  [6];
  logic [LumW-1:0]  lin_q  [6];
  logic [ProdW-1:0] prod_d [6];
  logic [ProdW-1:0] prod_q [6];
  logic [SumW-1:0]  fg_sum;
  logic [SumW-1:0]  bg_sum;
  logic [LumW-1:0]  fg_lum_q;
  logic [LumW-1:0]  bg_lum_q;
  logic             s1_vld_q;
  logic             s2_vld_q;
  logic             s3_vld_q;

  assign lin_w[0] = LinTab[fg_i.red][LumW-1:0];
  assign lin_w[1] = LinTab[fg_i.green][LumW-1:0];
  assign lin_w[2] = LinTab[fg_i.blue][LumW-1:0];
  assign lin_w[3] = LinTab[bg_i.red][LumW-1:0];
  assign lin_w[4] = LinTab[bg_i.green][LumW-1:0];
  assign lin_w[5] = LinTab[bg_i.blue][LumW-1:0];

  for (genvar k = 0; k < 6; k++) begin : g_mul
    localparam logic [WeightW-1:0] Wgt = ((k % 3) == 0) ? WeightRed :
                                         ((k % 3) == 1) ? WeightGreen : WeightBlue;
    assign prod_d[k] = ProdW'(lin_q[k]) * ProdW'(Wgt);
  end

  assign fg_sum = SumW'(prod_q[0]) + SumW'(prod_q[1]) + SumW'(prod_q[2]);
  assign bg_sum = SumW'(prod_q[3]) + SumW'(prod_q[4]) + SumW'(prod_q[5]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 6; k++) begin
      lin_q[k]  <= lin_w[k];
      prod_q[k] <= prod_d[k];
    end
    fg_lum_q <= fg_sum[WeightW +: LumW];
    bg_lum_q <= bg_sum[WeightW +: LumW];
  end

  always_comb begin
    if (fg_lum_q > bg_lum_q) begin
      bright_o = DenW'(fg_lum_q) + Offset;
      dark_o   = DenW'(bg_lum_q) + Offset;
    end else begin
      bright_o = DenW'(bg_lum_q) + Offset;
      dark_o   = DenW'(fg_lum_q) + Offset;
    end
  end

  assign push_o     = s3_vld_q;
  assign inflight_o = 2'(s1_vld_q) + 2'(s2_vld_q) + 2'(s3_vld_q);

endmodule

@@ rtl/core/wcg_fifo.sv @@
// Small register FIFO that decouples the front end from the divider.
// Depends on wcg_pkg for its default depth.
module wcg_fifo
  import wcg_pkg::*;
#(
  parameter int Width = 36,
  parameter int Depth = FifoDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           data_i,
  input  logic                       pop_i,
  output logic [Width-1:0]           data_o,
  output logic [$clog2(Depth+1)-1:0] cnt_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q;
  logic [PtrW-1:0]  rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic [CntW-1:0]  cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o = mem_q[rd_ptr_q];
  assign cnt_o  = cnt_q;

endmodule

@@ rtl/core/wcg_back.sv @@
// Back end of the contrast grader: pipelined restoring divider, one quotient
// bit per stage, then saturation and grading. Depends on wcg_pkg.
module wcg_back
  import wcg_pkg::*;
#(
  parameter int RatioFracBits = RatioFracBitsDef,
  parameter int DenW          = LumFracBitsDef + 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  logic [DenW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output result_t         res_o
);

  localparam int QuoW = RatioIntBits + RatioFracBits;
  localparam int NumW = DenW + RatioFracBits;
  localparam int CmpW = DenW + QuoW;
  localparam logic [QuoW-1:0] RatioMax = QuoW'(RatioSatInt << RatioFracBits);
  localparam logic [QuoW-1:0] Thr7     = QuoW'(7 << RatioFracBits);
  localparam logic [QuoW-1:0] Thr45    = QuoW'((9 << RatioFracBits) >> 1);
  localparam logic [QuoW-1:0] Thr3     = QuoW'(3 << RatioFracBits);

  logic [QuoW:0]     vld_q;
  logic [NumW-1:0]   rem_q [QuoW];
  logic [DenW-1:0]   den_q [QuoW];
  logic [QuoW-1:0]   quo_q [QuoW];
  logic [NumW-1:0]   rem_d [QuoW];
  logic [QuoW-1:0]   quo_d [QuoW];
  logic [QuoW-1:0]   qf_q;
  logic [QuoW-1:0]   sat;
  grade_e            grade;
  logic              done_q;
  result_t           res_q;

  // Stage j settles quotient bit QuoW-1-j; the quotient is known to fit.
  for (genvar j = 0; j < QuoW; j++) begin : g_step
    localparam int Sh = QuoW - 1 - j;
    logic [CmpW-1:0] dsh;
    logic            ge;
    assign dsh      = CmpW'(den_q[j]) << Sh;
    assign ge       = CmpW'(rem_q[j]) >= dsh;
    assign rem_d[j] = ge ? NumW'(CmpW'(rem_q[j]) - dsh) : rem_q[j];
    assign quo_d[j] = quo_q[j] | (QuoW'(ge) << Sh);
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= NumW'(num_i) << RatioFracBits;
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    for (int j = 1; j < QuoW; j++) begin
      rem_q[j] <= rem_d[j-1];
      den_q[j] <= den_q[j-1];
      quo_q[j] <= quo_d[j-1];
    end
    qf_q <= quo_d[QuoW-1];
  end

  assign sat = (qf_q > RatioMax) ? RatioMax : qf_q;

  always_comb begin
    if (sat >= Thr7) begin
      grade = GradeAaa;
    end else if (sat >= Thr45) begin
      grade = GradeAa;
    end else if (sat >= Thr3) begin
      grade = GradeAaLarge;
    end else begin
      grade = GradeFail;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[QuoW-1:0], vld_i};
      done_q <= vld_q[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.ratio      <= RatioW'(sat);
    res_q.grade_code <= grade;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ rtl/core/wcag_contrast_grader_top.sv @@
// Top level of the WCAG contrast grader: background registers, front end,
// decoupling FIFO and divider back end. Depends on wcg_pkg and all wcg_* modules.
//
// The block takes one foreground sRGB color per clock cycle and returns, for
// each, the WCAG 2 contrast ratio against the configured background color (in
// units of 1/2^RatioFracBits, truncated and saturated at 21) and its grade.
// For each accepted color, done_o is high for one cycle while res_o holds its
// result. The table lookup is registered at the accepting edge itself; after
// it come the luminance multipliers, the luminance sums, the FIFO, one divider
// stage per quotient bit (RatioFracBits + 5 of them), the quotient register and
// the output register. Since the receiver cannot stall and the divider advances
// every cycle, the FIFO holds at most one transaction and busy stays low in
// operation; it only reflects FIFO room reserved for colors still in the front
// end. Background registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i;
// a write to an index past the blue channel is ignored, and a color accepted in
// the cycle after a write already sees the new background. No clearing pass
// follows reset.
module wcag_contrast_grader_top
  import wcg_pkg::*;
#(
  parameter int LumFracBits   = LumFracBitsDef,
  parameter int RatioFracBits = RatioFracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  color_t             in_i,
  output logic               done_o,
  output result_t            res_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ChanW-1:0]   cfg_wdata_i
);

  localparam int DenW = LumFracBits + 2;
  localparam int CntW = $clog2(FifoDepth + 1);
  localparam int QuoW = RatioIntBits + RatioFracBits;

  color_t            bg_q;
  logic              accept;
  logic              push;
  logic [DenW-1:0]   bright;
  logic [DenW-1:0]   dark;
  logic [1:0]        inflight;
  logic [2*DenW-1:0] fifo_dout;
  logic [CntW-1:0]   fifo_cnt;
  logic              fifo_pop;

  // Background color registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q.red   <= BgRedRst;
      bg_q.green <= BgGreenRst;
      bg_q.blue  <= BgBlueRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgBgRed:   bg_q.red   <= cfg_wdata_i;
        CfgBgGreen: bg_q.green <= cfg_wdata_i;
        CfgBgBlue:  bg_q.blue  <= cfg_wdata_i;
        default:    bg_q       <= bg_q;
      endcase
    end
  end

  // Busy when the FIFO has no room for one more color beyond those already in flight.
  assign busy   = ((CntW + 1)'(fifo_cnt) + (CntW + 1)'(inflight)) >=
                  (CntW + 1)'(FifoDepth);
  assign accept = start && !busy;

  wcg_front #(
    .LumFracBits(LumFracBits)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .fg_i      (in_i),
    .bg_i      (bg_q),
    .push_o    (push),
    .bright_o  (bright),
    .dark_o    (dark),
    .inflight_o(inflight)
  );

  wcg_fifo #(
    .Width(2 * DenW),
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .data_i({bright, dark}),
    .pop_i (fifo_pop),
    .data_o(fifo_dout),
    .cnt_o (fifo_cnt)
  );

  // The divider never stalls, so it drains one entry whenever one is waiting.
  assign fifo_pop = (fifo_cnt != '0);

  wcg_back #(
    .RatioFracBits(RatioFracBits),
    .DenW         (DenW)
  ) u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (fifo_pop),
    .num_i (fifo_dout[2*DenW-1:DenW]),
    .den_i (fifo_dout[DenW-1:0]),
    .done_o(done_o),
    .res_o (res_o)
  );

`ifndef SYNTHESIS
  localparam int Latency = QuoW + 6;

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency done_o)
    else $error("accepted transaction did not complete at the fixed latency");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> ##Latency !done_o)
    else $error("result strobe without a matching accepted transaction");

  a_fifo_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fifo_cnt < CntW'(FifoDepth)))
    else $error("front end pushed into a full FIFO");
`endif

endmodule
